// File: hw/rtl/tcprs_pkg.sv
// ----------------------------------------------------------------------------
// tcprs_pkg
// Shared types and codes for the two-class priority runway scheduler.
// ----------------------------------------------------------------------------
package tcprs_pkg;

  // grant codes reported per server
  localparam logic [1:0] GRANT_NONE = 2'd0;
  localparam logic [1:0] GRANT_HIGH = 2'd1;
  localparam logic [1:0] GRANT_LOW  = 2'd2;

  // service time after reset
  localparam logic [7:0] SVC_RESET = 8'd15;

  // saturation limits
  localparam logic [15:0] DONE_MAX = 16'hFFFF;
  localparam logic [31:0] SUM_MAX  = 32'hFFFF_FFFF;

  // one queued request
  typedef struct packed {
    logic [15:0] plane;
    logic [15:0] stamp;
  } entry_t;

  // per-tick queue control
  typedef struct packed {
    logic       push;
    logic [1:0] pop;
  } queue_ctl_t;

  // one result transaction
  typedef struct packed {
    logic [1:0]  server0_grant;
    logic [15:0] server0_plane;
    logic [15:0] server0_wait;
    logic [1:0]  server1_grant;
    logic [15:0] server1_plane;
    logic [15:0] server1_wait;
    logic [5:0]  high_waiting;
    logic [5:0]  low_waiting;
    logic [15:0] high_done;
    logic [15:0] low_done;
    logic [31:0] high_wait_sum;
    logic [31:0] low_wait_sum;
  } result_t;

endpackage

// File: hw/rtl/tcprs_ram.sv
// ----------------------------------------------------------------------------
// tcprs_ram
// Generic RAM, one write port, two registered read ports, write-first.
// ----------------------------------------------------------------------------
module tcprs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // storage write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered reads, new data passed through on address match
  always_ff @(posedge clk) begin
    rdata_a <= (we && waddr == raddr_a) ? wdata : mem[raddr_a];
    rdata_b <= (we && waddr == raddr_b) ? wdata : mem[raddr_b];
  end

endmodule

// File: hw/rtl/tcprs_queue.sv
// ----------------------------------------------------------------------------
// tcprs_queue
// Request FIFO with up to one push and two pops per tick; the two head
// entries are prefetched from RAM so they are ready at the start of a tick.
// ----------------------------------------------------------------------------
module tcprs_queue #(
  parameter int DEPTH = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  tcprs_pkg::queue_ctl_t      ctl,
  input  tcprs_pkg::entry_t          push_data,
  output logic [$clog2(DEPTH+1)-1:0] count,
  output tcprs_pkg::entry_t          head0,
  output tcprs_pkg::entry_t          head1
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [AW-1:0] head;
  logic [AW-1:0] tail;
  logic [AW-1:0] head_next;
  logic [AW-1:0] tail_next;
  logic [CW-1:0] count_next;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  // pointer and fill level update
  always_comb begin
    tail_next  = ctl.push ? wrap_inc(tail) : tail;
    count_next = count + CW'(ctl.push) - CW'(ctl.pop);
    case (ctl.pop)
      2'd1:    head_next = wrap_inc(head);
      2'd2:    head_next = wrap_inc(wrap_inc(head));
      default: head_next = head;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  // entry storage, read at the next head and the one after it
  tcprs_ram #(
    .WIDTH ($bits(tcprs_pkg::entry_t)),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (ctl.push),
    .waddr   (tail),
    .wdata   (push_data),
    .raddr_a (head_next),
    .raddr_b (wrap_inc(head_next)),
    .rdata_a (head0),
    .rdata_b (head1)
  );

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue fill level above depth");

  a_pop_bound: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, count} + (CW+1)'(ctl.push)) >= (CW+1)'(ctl.pop))
    else $error("queue popped more entries than it holds");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    ctl.push |-> count != CW'(DEPTH))
    else $error("queue pushed while full");
`endif

endmodule

// File: hw/rtl/tcprs_outbuf.sv
// ----------------------------------------------------------------------------
// tcprs_outbuf
// Two-entry result buffer: output register plus skid register.
// ----------------------------------------------------------------------------
module tcprs_outbuf (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  tcprs_pkg::result_t push_data,
  output logic               can_push,
  output logic               out_valid,
  input  logic               out_ready,
  output tcprs_pkg::result_t out_data
);

  tcprs_pkg::result_t skid;
  logic               skid_valid;
  logic               pop;

  assign pop      = out_valid && out_ready;
  assign can_push = !skid_valid;

  // valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      out_valid  <= skid_valid || push;
      skid_valid <= 1'b0;
    end else if (push) begin
      out_valid  <= 1'b1;
      skid_valid <= out_valid;
    end
  end

  // payload moves
  always_ff @(posedge clk) begin
    if (pop) begin
      out_data <= skid_valid ? skid : push_data;
    end else if (push && !out_valid) begin
      out_data <= push_data;
    end
    if (push && out_valid && !pop) begin
      skid <= push_data;
    end
  end

`ifndef ASSERT_OFF
  a_skid_order: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held with empty output register");
`endif

endmodule

// File: hw/rtl/two_class_priority_runway_scheduler.sv
// ----------------------------------------------------------------------------
// two_class_priority_runway_scheduler
// Strict-priority two-queue scheduler: each transaction is one tick that may
// queue a landing or takeoff request, then free servers take requests,
// landings first.
//
//   channel  signals                          direction  payload
//   in       in_valid / in_ready              input      has_request, is_high_class
//   out      out_valid / out_ready            output     grants, fill levels, stats
//   cfg      cfg_we / cfg_wdata               input      service_time
//
// One tick per clock cycle while in_ready is high; the result is registered
// in the output buffer. Each accepted transaction updates the state of the
// queues, servers and counters.
// Reset empties both queues, frees all servers, zeroes tick, counters and
// sums, sets the next plane id to 1 and service_time to 15.
// A stalled output keeps up to two results; in_ready drops when both are held.
// ----------------------------------------------------------------------------
module two_class_priority_runway_scheduler #(
  parameter int QUEUE_DEPTH = 32,
  parameter int SERVERS     = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        has_request,
  input  logic        is_high_class,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  server0_grant,
  output logic [15:0] server0_plane,
  output logic [15:0] server0_wait,
  output logic [1:0]  server1_grant,
  output logic [15:0] server1_plane,
  output logic [15:0] server1_wait,
  output logic [5:0]  high_waiting,
  output logic [5:0]  low_waiting,
  output logic [15:0] high_done,
  output logic [15:0] low_done,
  output logic [31:0] high_wait_sum,
  output logic [31:0] low_wait_sum
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  // state
  logic [7:0]  service_time;
  logic [7:0]  busy [SERVERS];
  logic [15:0] tick_now;
  logic [15:0] next_plane_id;
  logic [15:0] done_h;
  logic [15:0] done_l;
  logic [31:0] sum_h;
  logic [31:0] sum_l;

  // queue side
  tcprs_pkg::queue_ctl_t h_ctl;
  tcprs_pkg::queue_ctl_t l_ctl;
  tcprs_pkg::entry_t     new_entry;
  tcprs_pkg::entry_t     h_head0;
  tcprs_pkg::entry_t     h_head1;
  tcprs_pkg::entry_t     l_head0;
  tcprs_pkg::entry_t     l_head1;
  logic [CW-1:0]         h_cnt;
  logic [CW-1:0]         l_cnt;

  // tick logic
  logic                accept;
  logic                h_push;
  logic                l_push;
  logic [CW:0]         h_avail;
  logic [CW:0]         l_avail;
  tcprs_pkg::entry_t   h_el0;
  tcprs_pkg::entry_t   h_el1;
  tcprs_pkg::entry_t   l_el0;
  tcprs_pkg::entry_t   l_el1;
  logic [1:0]          srv_free;
  logic                g0_h;
  logic                g0_l;
  logic                g1_h;
  logic                g1_l;
  tcprs_pkg::entry_t   e0;
  tcprs_pkg::entry_t   e1;
  logic [15:0]         w0;
  logic [15:0]         w1;
  logic [CW-1:0]       h_cnt_after;
  logic [CW-1:0]       l_cnt_after;
  logic [16:0]         done_h_sum;
  logic [16:0]         done_l_sum;
  logic [33:0]         sum_h_total;
  logic [33:0]         sum_l_total;
  logic [15:0]         done_h_next;
  logic [15:0]         done_l_next;
  logic [31:0]         sum_h_next;
  logic [31:0]         sum_l_next;
  logic [15:0]         plane_inc;
  logic [7:0]          busy_load;
  tcprs_pkg::result_t  res;
  tcprs_pkg::result_t  out_res;

  assign accept = in_valid && in_ready;

  // server free flags, absent servers never free
  for (genvar s = 0; s < 2; s++) begin : g_free
    if (s < SERVERS) begin : g_on
      assign srv_free[s] = (busy[s] == 8'd0);
    end else begin : g_off
      assign srv_free[s] = 1'b0;
    end
  end

  // request push and candidate entries, the new request can be granted at once
  always_comb begin
    new_entry.plane = next_plane_id;
    new_entry.stamp = tick_now;
    h_push  = accept && has_request && is_high_class && (h_cnt != CW'(QUEUE_DEPTH));
    l_push  = accept && has_request && !is_high_class && (l_cnt != CW'(QUEUE_DEPTH));
    h_avail = {1'b0, h_cnt} + (CW+1)'(h_push);
    l_avail = {1'b0, l_cnt} + (CW+1)'(l_push);
    h_el0   = (h_cnt != '0) ? h_head0 : new_entry;
    h_el1   = (h_cnt > CW'(1)) ? h_head1 : new_entry;
    l_el0   = (l_cnt != '0) ? l_head0 : new_entry;
    l_el1   = (l_cnt > CW'(1)) ? l_head1 : new_entry;
  end

  // server grants in order, landings first
  always_comb begin
    g0_h = accept && srv_free[0] && (h_avail != '0);
    g0_l = accept && srv_free[0] && !g0_h && (l_avail != '0);
    g1_h = accept && srv_free[1] &&
           (g0_h ? (h_avail > (CW+1)'(1)) : (h_avail != '0));
    g1_l = accept && srv_free[1] && !g1_h &&
           (g0_l ? (l_avail > (CW+1)'(1)) : (l_avail != '0));
    e0   = g0_h ? h_el0 : l_el0;
    if (g1_h) begin
      e1 = g0_h ? h_el1 : h_el0;
    end else begin
      e1 = g0_l ? l_el1 : l_el0;
    end
    w0 = tick_now - e0.stamp;
    w1 = tick_now - e1.stamp;
  end

  // queue control
  always_comb begin
    h_ctl.push = h_push;
    h_ctl.pop  = 2'(g0_h) + 2'(g1_h);
    l_ctl.push = l_push;
    l_ctl.pop  = 2'(g0_l) + 2'(g1_l);
    h_cnt_after = h_cnt + CW'(h_ctl.push) - CW'(h_ctl.pop);
    l_cnt_after = l_cnt + CW'(l_ctl.push) - CW'(l_ctl.pop);
  end

  // saturating statistics
  always_comb begin
    done_h_sum  = {1'b0, done_h} + 17'(g0_h) + 17'(g1_h);
    done_l_sum  = {1'b0, done_l} + 17'(g0_l) + 17'(g1_l);
    sum_h_total = {2'b00, sum_h} + 34'(g0_h ? w0 : 16'd0) + 34'(g1_h ? w1 : 16'd0);
    sum_l_total = {2'b00, sum_l} + 34'(g0_l ? w0 : 16'd0) + 34'(g1_l ? w1 : 16'd0);
    done_h_next = done_h_sum[16] ? tcprs_pkg::DONE_MAX : done_h_sum[15:0];
    done_l_next = done_l_sum[16] ? tcprs_pkg::DONE_MAX : done_l_sum[15:0];
    sum_h_next  = (sum_h_total[33:32] != 2'b00) ? tcprs_pkg::SUM_MAX : sum_h_total[31:0];
    sum_l_next  = (sum_l_total[33:32] != 2'b00) ? tcprs_pkg::SUM_MAX : sum_l_total[31:0];
    plane_inc   = next_plane_id + 16'd1;
    busy_load   = (service_time == 8'd0) ? 8'd0 : service_time - 8'd1;
  end

  // result assembly
  always_comb begin
    res = '0;
    if (g0_h || g0_l) begin
      res.server0_grant = g0_h ? tcprs_pkg::GRANT_HIGH : tcprs_pkg::GRANT_LOW;
      res.server0_plane = e0.plane;
      res.server0_wait  = w0;
    end
    if (g1_h || g1_l) begin
      res.server1_grant = g1_h ? tcprs_pkg::GRANT_HIGH : tcprs_pkg::GRANT_LOW;
      res.server1_plane = e1.plane;
      res.server1_wait  = w1;
    end
    res.high_waiting  = 6'(h_cnt_after);
    res.low_waiting   = 6'(l_cnt_after);
    res.high_done     = done_h_next;
    res.low_done      = done_l_next;
    res.high_wait_sum = sum_h_next;
    res.low_wait_sum  = sum_l_next;
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      service_time <= tcprs_pkg::SVC_RESET;
    end else if (cfg_we) begin
      service_time <= cfg_wdata;
    end
  end

  // tick, plane id and statistics
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_now      <= '0;
      next_plane_id <= 16'd1;
      done_h        <= '0;
      done_l        <= '0;
      sum_h         <= '0;
      sum_l         <= '0;
    end else if (accept) begin
      tick_now <= tick_now + 16'd1;
      if (has_request) begin
        next_plane_id <= (plane_inc == 16'd0) ? 16'd1 : plane_inc;
      end
      done_h <= done_h_next;
      done_l <= done_l_next;
      sum_h  <= sum_h_next;
      sum_l  <= sum_l_next;
    end
  end

  // server busy counters
  for (genvar s = 0; s < SERVERS; s++) begin : g_busy
    logic granted;
    if (s == 0) begin : g_s0
      assign granted = g0_h || g0_l;
    end else begin : g_s1
      assign granted = g1_h || g1_l;
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        busy[s] <= '0;
      end else if (accept) begin
        if (granted) begin
          busy[s] <= busy_load;
        end else if (busy[s] != 8'd0) begin
          busy[s] <= busy[s] - 8'd1;
        end
      end
    end
  end

  // landing and takeoff queues
  tcprs_queue #(.DEPTH(QUEUE_DEPTH)) u_high_q (
    .clk       (clk),
    .rst       (rst),
    .ctl       (h_ctl),
    .push_data (new_entry),
    .count     (h_cnt),
    .head0     (h_head0),
    .head1     (h_head1)
  );

  tcprs_queue #(.DEPTH(QUEUE_DEPTH)) u_low_q (
    .clk       (clk),
    .rst       (rst),
    .ctl       (l_ctl),
    .push_data (new_entry),
    .count     (l_cnt),
    .head0     (l_head0),
    .head1     (l_head1)
  );

  // result buffer
  tcprs_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (res),
    .can_push  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_res)
  );

  assign server0_grant = out_res.server0_grant;
  assign server0_plane = out_res.server0_plane;
  assign server0_wait  = out_res.server0_wait;
  assign server1_grant = out_res.server1_grant;
  assign server1_plane = out_res.server1_plane;
  assign server1_wait  = out_res.server1_wait;
  assign high_waiting  = out_res.high_waiting;
  assign low_waiting   = out_res.low_waiting;
  assign high_done     = out_res.high_done;
  assign low_done      = out_res.low_done;
  assign high_wait_sum = out_res.high_wait_sum;
  assign low_wait_sum  = out_res.low_wait_sum;

`ifndef ASSERT_OFF
  a_busy_no_grant: assert property (@(posedge clk) disable iff (rst)
    (accept && busy[0] != 8'd0) |-> !(g0_h || g0_l))
    else $error("busy server 0 received a grant");

  a_grant_plane: assert property (@(posedge clk) disable iff (rst)
    (g0_h || g0_l) |-> e0.plane != 16'd0)
    else $error("grant carries plane id zero");

  a_landing_first: assert property (@(posedge clk) disable iff (rst)
    g0_l |-> h_avail == '0)
    else $error("takeoff granted while a landing waits");
`endif

endmodule

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the two-class priority runway scheduler. A short
// stimulus table covers reset values, both request classes, a tick with no
// request, priority of landings over takeoffs and the end of a busy period.
// It is followed by random traffic at several service times: 255, 0, 1 and
// random values, and a last phase with a long service time so that both
// queues fill again. Every result transaction is compared field by field
// against its table row if given, else a behavioral schedule model in the bench.
// ----------------------------------------------------------------------------
module tb;

  localparam int QUEUE_DEPTH = 32;
  localparam int HOLD_CYCLES = 80;
  localparam int RUN_LIMIT   = 1_000_000;
  localparam tcprs_pkg::result_t NO_RESULT = '0;

  // one row of the opening stimulus table
  typedef struct {
    logic               req;
    logic               hi;
    bit                 typed;
    tcprs_pkg::result_t want;
  } tick_row_t;

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        cfg_we        = 1'b0;
  logic [7:0]  cfg_wdata     = 8'd0;
  logic        in_valid      = 1'b0;
  logic        has_request   = 1'b0;
  logic        is_high_class = 1'b0;
  logic        out_ready     = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [1:0]  server0_grant;
  logic [15:0] server0_plane;
  logic [15:0] server0_wait;
  logic [1:0]  server1_grant;
  logic [15:0] server1_plane;
  logic [15:0] server1_wait;
  logic [5:0]  high_waiting;
  logic [5:0]  low_waiting;
  logic [15:0] high_done;
  logic [15:0] low_done;
  logic [31:0] high_wait_sum;
  logic [31:0] low_wait_sum;

  // schedule model state
  tcprs_pkg::entry_t landing_q[$];
  tcprs_pkg::entry_t takeoff_q[$];
  logic [7:0]        runway_busy [2];
  logic [15:0]       tick_cnt;
  logic [15:0]       next_plane;
  logic [15:0]       granted_cnt [2];
  logic [31:0]       wait_total [2];
  logic [7:0]        service_ticks;

  tcprs_pkg::result_t pending_results[$];
  tick_row_t          opening_rows[24];
  bit                 gaps_on      = 1'b1;
  bit                 hold_off_req = 1'b0;
  int                 mismatches   = 0;
  int                 cycle_count  = 0;
  tcprs_pkg::result_t dut_result;

  always #5 clk = ~clk;

  two_class_priority_runway_scheduler #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .SERVERS     (2)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .has_request   (has_request),
    .is_high_class (is_high_class),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .server0_grant (server0_grant),
    .server0_plane (server0_plane),
    .server0_wait  (server0_wait),
    .server1_grant (server1_grant),
    .server1_plane (server1_plane),
    .server1_wait  (server1_wait),
    .high_waiting  (high_waiting),
    .low_waiting   (low_waiting),
    .high_done     (high_done),
    .low_done      (low_done),
    .high_wait_sum (high_wait_sum),
    .low_wait_sum  (low_wait_sum)
  );

  assign dut_result = {server0_grant, server0_plane, server0_wait,
                       server1_grant, server1_plane, server1_wait,
                       high_waiting, low_waiting, high_done, low_done,
                       high_wait_sum, low_wait_sum};

  // model state after reset
  task automatic clear_schedule();
    landing_q.delete();
    takeoff_q.delete();
    for (int s = 0; s < 2; s++) begin
      runway_busy[s] = 8'd0;
      granted_cnt[s] = 16'd0;
      wait_total[s]  = 32'd0;
    end
    tick_cnt      = 16'd0;
    next_plane    = 16'd1;
    service_ticks = tcprs_pkg::SVC_RESET;
  endtask

  // one tick of the scheduler: queue the request, grant free runways, count
  task automatic schedule_tick(input logic req, input logic hi,
                               output tcprs_pkg::result_t r);
    tcprs_pkg::entry_t head;
    tcprs_pkg::entry_t fresh;
    logic [15:0]       dly;
    logic [32:0]       acc;
    logic [1:0]        code;
    int                cls;
    r = '0;
    if (req) begin
      fresh.plane = next_plane;
      fresh.stamp = tick_cnt;
      if (hi) begin
        if (landing_q.size() < QUEUE_DEPTH) landing_q.insert(landing_q.size(), fresh);
      end else begin
        if (takeoff_q.size() < QUEUE_DEPTH) takeoff_q.insert(takeoff_q.size(), fresh);
      end
      // plane id 0 is reserved for no grant
      next_plane = (next_plane == 16'hFFFF) ? 16'd1 : next_plane + 16'd1;
    end
    for (int s = 0; s < 2; s++) begin
      if (runway_busy[s] == 8'd0 && (landing_q.size() != 0 || takeoff_q.size() != 0)) begin
        if (landing_q.size() != 0) begin
          cls  = 0;
          code = tcprs_pkg::GRANT_HIGH;
          head = landing_q.pop_front();
        end else begin
          cls  = 1;
          code = tcprs_pkg::GRANT_LOW;
          head = takeoff_q.pop_front();
        end
        dly = tick_cnt - head.stamp;
        if (s == 0) begin
          r.server0_grant = code;
          r.server0_plane = head.plane;
          r.server0_wait  = dly;
        end else begin
          r.server1_grant = code;
          r.server1_plane = head.plane;
          r.server1_wait  = dly;
        end
        if (granted_cnt[cls] != tcprs_pkg::DONE_MAX) granted_cnt[cls]++;
        acc = {1'b0, wait_total[cls]} + {17'd0, dly};
        wait_total[cls] = acc[32] ? tcprs_pkg::SUM_MAX : acc[31:0];
        runway_busy[s]  = service_ticks;
      end
    end
    // busy countdown, so a zero service time behaves like one
    for (int s = 0; s < 2; s++)
      if (runway_busy[s] != 8'd0) runway_busy[s]--;
    tick_cnt++;
    r.high_waiting  = 6'(landing_q.size());
    r.low_waiting   = 6'(takeoff_q.size());
    r.high_done     = granted_cnt[0];
    r.low_done      = granted_cnt[1];
    r.high_wait_sum = wait_total[0];
    r.low_wait_sum  = wait_total[1];
  endtask

  function automatic tcprs_pkg::result_t snapshot(
    input logic [1:0] g0, input logic [15:0] p0, input logic [15:0] w0,
    input logic [1:0] g1, input logic [15:0] p1, input logic [15:0] w1,
    input logic [5:0] hw, input logic [5:0] lw,
    input logic [15:0] hd, input logic [15:0] ld,
    input logic [31:0] hs, input logic [31:0] ls);
    return {g0, p0, w0, g1, p1, w1, hw, lw, hd, ld, hs, ls};
  endfunction

  // offer one tick transaction, with random idle cycles ahead of it while gaps are on
  task automatic send_tick(input logic req, input logic hi, input bit typed,
                           input tcprs_pkg::result_t typed_want);
    tcprs_pkg::result_t predicted;
    @(negedge clk);
    while (gaps_on && $urandom_range(99) < 33) begin
      in_valid      <= 1'b0;
      has_request   <= 1'($urandom);
      is_high_class <= 1'($urandom);
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    has_request   <= req;
    is_high_class <= hi;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    schedule_tick(req, hi, predicted);
    pending_results.insert(pending_results.size(), typed ? typed_want : predicted);
  endtask

  // stop offering and wait until every expected result has come out
  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // service time is only changed while the block is idle
  task automatic write_service(input logic [7:0] value);
    wait_for_results();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we        <= 1'b0;
    service_ticks = value;
  endtask

  task automatic run_phase(input int count, input int req_pct, input int high_pct);
    for (int i = 0; i < count; i++)
      send_tick($urandom_range(99) < req_pct, $urandom_range(99) < high_pct, 1'b0,
                NO_RESULT);
  endtask

  task automatic compare_field(input string tag, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %0d, got %0d", tag, want, got);
    end
  endtask

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end else begin
        out_ready <= !(gaps_on && $urandom_range(99) < 33);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    tcprs_pkg::result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result transaction with nothing pending");
      end else begin
        want = pending_results.pop_front();
        compare_field("server0_grant", want.server0_grant, dut_result.server0_grant);
        compare_field("server0_plane", want.server0_plane, dut_result.server0_plane);
        compare_field("server0_wait", want.server0_wait, dut_result.server0_wait);
        compare_field("server1_grant", want.server1_grant, dut_result.server1_grant);
        compare_field("server1_plane", want.server1_plane, dut_result.server1_plane);
        compare_field("server1_wait", want.server1_wait, dut_result.server1_wait);
        compare_field("high_waiting", want.high_waiting, dut_result.high_waiting);
        compare_field("low_waiting", want.low_waiting, dut_result.low_waiting);
        compare_field("high_done", want.high_done, dut_result.high_done);
        compare_field("low_done", want.low_done, dut_result.low_done);
        compare_field("high_wait_sum", want.high_wait_sum, dut_result.high_wait_sum);
        compare_field("low_wait_sum", want.low_wait_sum, dut_result.low_wait_sum);
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("two_class_priority_runway_scheduler test failed");
      $finish;
    end
  end

  initial begin
    // opening table: reset values, both classes, landing priority, busy end
    opening_rows = '{
      '{1'b0, 1'b1, 1'b1, snapshot(tcprs_pkg::GRANT_NONE, 0, 0, tcprs_pkg::GRANT_NONE,
                                   0, 0, 0, 0, 0, 0, 0, 0)},
      '{1'b1, 1'b0, 1'b1, snapshot(tcprs_pkg::GRANT_LOW, 1, 0, tcprs_pkg::GRANT_NONE,
                                   0, 0, 0, 0, 0, 1, 0, 0)},
      '{1'b1, 1'b1, 1'b1, snapshot(tcprs_pkg::GRANT_NONE, 0, 0, tcprs_pkg::GRANT_HIGH,
                                   2, 0, 0, 0, 1, 1, 0, 0)},
      '{1'b1, 1'b1, 1'b1, snapshot(tcprs_pkg::GRANT_NONE, 0, 0, tcprs_pkg::GRANT_NONE,
                                   0, 0, 1, 0, 1, 1, 0, 0)},
      '{1'b1, 1'b0, 1'b1, snapshot(tcprs_pkg::GRANT_NONE, 0, 0, tcprs_pkg::GRANT_NONE,
                                   0, 0, 1, 1, 1, 1, 0, 0)},
      '{1'b0, 1'b0, 1'b0, NO_RESULT},
      '{1'b0, 1'b1, 1'b0, NO_RESULT},
      '{1'b0, 1'b0, 1'b0, NO_RESULT},
      '{1'b0, 1'b1, 1'b0, NO_RESULT},
      '{1'b0, 1'b0, 1'b0, NO_RESULT},
      '{1'b0, 1'b1, 1'b0, NO_RESULT},
      '{1'b0, 1'b0, 1'b0, NO_RESULT},
      '{1'b0, 1'b1, 1'b0, NO_RESULT},
      '{1'b0, 1'b0, 1'b0, NO_RESULT},
      '{1'b0, 1'b1, 1'b0, NO_RESULT},
      '{1'b0, 1'b0, 1'b0, NO_RESULT},
      '{1'b0, 1'b0, 1'b1, snapshot(tcprs_pkg::GRANT_HIGH, 3, 13, tcprs_pkg::GRANT_NONE,
                                   0, 0, 0, 1, 2, 1, 13, 0)},
      '{1'b0, 1'b1, 1'b1, snapshot(tcprs_pkg::GRANT_NONE, 0, 0, tcprs_pkg::GRANT_LOW,
                                   4, 13, 0, 0, 2, 2, 13, 13)},
      '{1'b1, 1'b0, 1'b0, NO_RESULT},
      '{1'b1, 1'b1, 1'b0, NO_RESULT},
      '{1'b1, 1'b0, 1'b0, NO_RESULT},
      '{1'b1, 1'b1, 1'b0, NO_RESULT},
      '{1'b0, 1'b0, 1'b0, NO_RESULT},
      '{1'b1, 1'b1, 1'b0, NO_RESULT}
    };

    clear_schedule();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (opening_rows[i])
      send_tick(opening_rows[i].req, opening_rows[i].hi, opening_rows[i].typed,
                opening_rows[i].want);

    // long service: queues fill and drop, receiver holds off meanwhile
    write_service(8'd255);
    hold_off_req = 1'b1;
    run_phase(160, 90, 50);

    // zero and shortest service time
    write_service(8'd0);
    run_phase(160, 70, 50);
    write_service(8'd1);
    run_phase(160, 100, 30);

    // stretch with no idling on either side
    gaps_on = 1'b0;
    write_service(8'($urandom_range(40, 2)));
    run_phase(160, 60, 60);
    gaps_on = 1'b1;
    write_service(8'($urandom_range(255, 1)));
    run_phase(160, 80, 70);

    // long service again, queues back up with random idling
    write_service(8'd100);
    run_phase(130, 70, 50);

    wait_for_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("two_class_priority_runway_scheduler test passed");
    end else begin
      $display("two_class_priority_runway_scheduler test failed");
    end
    $finish;
  end

endmodule
